/* rtl/core/rrai_pkg.sv */
// Shared types, constants and the arctangent table for the rotated rectangle
// angular interval pipeline. No dependencies.
package rrai_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [31:0] COS_GAIN_Q30 = 32'sd652032874;
    localparam logic [31:0] QUARTER_TURN32 = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN32 = 32'h8000_0000;
    localparam logic [15:0] ANG_ZERO = 16'd0;
    localparam logic [15:0] ANG_QUARTER = 16'd16384;
    localparam logic [15:0] ANG_HALF = 16'd32768;
    localparam logic [15:0] ANG_THREE_Q = 16'd49152;

    // Fractional bits of the coordinate fields; angles do not depend on it
    localparam int COORD_FRAC_BITS = 8;

    // Corner offsets are 16x32 products, sums fit in 50 bits; positions in 58
    localparam int OFS_W = 50;
    localparam int POS_W = 58;
    localparam int VEC_W = 60;

    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;
            5'd19: v = 32'd1303;
            5'd20: v = 32'd651;
            5'd21: v = 32'd325;
            5'd22: v = 32'd162;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Corner angle special cases carried alongside the vectoring pipeline
    typedef enum logic [2:0] {
        t_SP_NONE, t_SP_ZERO, t_SP_QUARTER, t_SP_HALF, t_SP_THREE_Q
    } t_special;

endpackage

/* rtl/core/rrai_rot_cordic.sv */
// Pipelined rotation-mode CORDIC: turns a 16-bit turn angle into Q30 cosine
// and sine, one register stage per iteration. Uses rrai_pkg.
module rrai_rot_cordic import rrai_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic [15:0]        i_turns,
    output logic               o_valid,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [1:0]         q;
    } t_rot;

    t_rot       r_st [STAGES+1];
    logic [STAGES:0] r_vld;
    t_rot       n_in;
    logic [31:0] theta;
    logic [32:0] tq;

    always_comb begin
        theta = {i_turns, 16'd0};
        // keep the carry: the top eighth of a turn folds back to quadrant 0
        tq = {1'b0, theta} + {1'b0, QUARTER_TURN32 >> 1};
        n_in.q = tq[31:30];
        n_in.z = $signed({2'b00, theta}) - $signed({1'b0, tq[32:30], 30'd0});
        n_in.x = 34'(COS_GAIN_Q30);
        n_in.y = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st[0] <= n_in;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_rot n_st;
        always_comb begin
            n_st = r_st[g];
            if (!r_st[g].z[33]) begin
                n_st.x = r_st[g].x - (r_st[g].y >>> g);
                n_st.y = r_st[g].y + (r_st[g].x >>> g);
                n_st.z = r_st[g].z - $signed({2'b00, atan_turn32(5'(g))});
            end else begin
                n_st.x = r_st[g].x + (r_st[g].y >>> g);
                n_st.y = r_st[g].y - (r_st[g].x >>> g);
                n_st.z = r_st[g].z + $signed({2'b00, atan_turn32(5'(g))});
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[g+1] <= n_st;
            end
        end
    end

    always_comb begin
        case (r_st[STAGES].q)
            2'd0: begin
                o_cos = 32'(r_st[STAGES].x); o_sin = 32'(r_st[STAGES].y);
            end
            2'd1: begin
                o_cos = 32'(-r_st[STAGES].y); o_sin = 32'(r_st[STAGES].x);
            end
            2'd2: begin
                o_cos = 32'(-r_st[STAGES].x); o_sin = 32'(-r_st[STAGES].y);
            end
            default: begin
                o_cos = 32'(r_st[STAGES].y); o_sin = 32'(-r_st[STAGES].x);
            end
        endcase
    end
    assign o_valid = r_vld[STAGES];

endmodule

/* rtl/core/rrai_vec_cordic.sv */
// Pipelined vectoring-mode CORDIC: polar angle of one corner in 16-bit turn
// units, with axis and origin cases bypassed. Uses rrai_pkg.
module rrai_vec_cordic import rrai_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_adv,
    input  logic signed [POS_W-1:0] i_x,
    input  logic signed [POS_W-1:0] i_y,
    output logic [15:0]             o_angle
);

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [31:0]             z;
        t_special                sp;
    } t_vec;

    t_vec r_st [STAGES+1];
    t_vec n_in;

    always_comb begin
        n_in.x = VEC_W'(i_x);
        n_in.y = VEC_W'(i_y);
        n_in.z = '0;
        n_in.sp = t_SP_NONE;
        if (i_y == '0) begin
            n_in.sp = i_x[POS_W-1] ? t_SP_HALF : t_SP_ZERO;
        end else if (i_x == '0) begin
            n_in.sp = i_y[POS_W-1] ? t_SP_THREE_Q : t_SP_QUARTER;
        end else if (i_x[POS_W-1]) begin
            n_in.x = -VEC_W'(i_x);
            n_in.y = -VEC_W'(i_y);
            n_in.z = HALF_TURN32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st[0] <= n_in;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_vec n_st;
        always_comb begin
            n_st = r_st[g];
            if (!r_st[g].y[VEC_W-1] && r_st[g].y != '0) begin
                n_st.x = r_st[g].x + (r_st[g].y >>> g);
                n_st.y = r_st[g].y - (r_st[g].x >>> g);
                n_st.z = r_st[g].z + atan_turn32(5'(g));
            end else begin
                n_st.x = r_st[g].x - (r_st[g].y >>> g);
                n_st.y = r_st[g].y + (r_st[g].x >>> g);
                n_st.z = r_st[g].z - atan_turn32(5'(g));
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[g+1] <= n_st;
            end
        end
    end

    always_comb begin
        case (r_st[STAGES].sp)
            t_SP_ZERO:    o_angle = ANG_ZERO;
            t_SP_QUARTER: o_angle = ANG_QUARTER;
            t_SP_HALF:    o_angle = ANG_HALF;
            t_SP_THREE_Q: o_angle = ANG_THREE_Q;
            default:      o_angle = r_st[STAGES].z[31:16];
        endcase
    end

endmodule

/* rtl/core/rotated_rect_angular_interval.sv */
// Top level: rotation CORDIC, corner product stages, four vectoring CORDICs
// and min/max reduction. Uses rrai_pkg, rrai_rot_cordic, rrai_vec_cordic.

// Takes one rectangle per cycle, unless stalled, and returns the angular
// interval it covers seen from the origin. Each rectangle passes through the
// two CORDIC pipelines in series (CORDIC_STAGES + 1 registers each) plus the
// product, sum, reduction and output stages; throughput is one transaction
// per cycle when not stalled. While o_out_valid is high, i_out_stall freezes
// the whole pipeline; o_in_stall follows it and the output register holds.
module rotated_rect_angular_interval import rrai_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [19:0] i_center_x,
    input  logic signed [19:0] i_center_y,
    input  logic [15:0]        i_rect_width,
    input  logic [15:0]        i_rect_height,
    input  logic [15:0]        i_rotation_turns,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [16:0]        o_start_angle,
    output logic [16:0]        o_end_angle,
    output logic               o_full_circle
);

    localparam int ROT_LAT = CORDIC_STAGES + 1;
    localparam int VEC_LAT = CORDIC_STAGES + 1;

    logic adv;
    logic out_busy;
    assign out_busy = o_out_valid && i_out_stall;
    assign adv = !out_busy;
    assign o_in_stall = out_busy;

    // Rotation CORDIC
    logic               rot_vld;
    logic signed [31:0] rot_cos, rot_sin;
    rrai_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(i_in_valid), .i_turns(i_rotation_turns),
        .o_valid(rot_vld), .o_cos(rot_cos), .o_sin(rot_sin)
    );

    // Delay geometry alongside rotation
    typedef struct packed {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic [15:0]        w;
        logic [15:0]        h;
    } t_geo;
    t_geo r_geo [ROT_LAT];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_geo[0] <= '{i_center_x, i_center_y, i_rect_width, i_rect_height};
            for (int k = 1; k < ROT_LAT; k++) r_geo[k] <= r_geo[k-1];
        end
    end
    t_geo geo_d;
    assign geo_d = r_geo[ROT_LAT-1];

    // Stage P: four products
    logic signed [48:0] r_wc, r_ws, r_hc, r_hs;
    logic signed [19:0] r_pcx, r_pcy;
    logic               r_pv;
    // Stage S: corner positions
    logic signed [POS_W-1:0] r_px [4];
    logic signed [POS_W-1:0] r_py [4];
    logic                    r_sv;

    logic signed [OFS_W-1:0] xo [4];
    logic signed [OFS_W-1:0] yo [4];
    logic signed [POS_W-1:0] cxs, cys;

    always_comb begin
        // corners: (-w,-h), (w,-h), (w,h), (-w,h)
        xo[0] = (-r_wc + r_hs) >>> 11; yo[0] = (-r_ws - r_hc) >>> 11;
        xo[1] = ( r_wc + r_hs) >>> 11; yo[1] = ( r_ws - r_hc) >>> 11;
        xo[2] = ( r_wc - r_hs) >>> 11; yo[2] = ( r_ws + r_hc) >>> 11;
        xo[3] = (-r_wc - r_hs) >>> 11; yo[3] = (-r_ws + r_hc) >>> 11;
        cxs = {{(POS_W-40){r_pcx[19]}}, r_pcx, 20'd0};
        cys = {{(POS_W-40){r_pcy[19]}}, r_pcy, 20'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_sv <= 1'b0;
        end else if (adv) begin
            r_pv <= rot_vld;
            r_sv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wc <= $signed({1'b0, geo_d.w}) * rot_cos;
            r_ws <= $signed({1'b0, geo_d.w}) * rot_sin;
            r_hc <= $signed({1'b0, geo_d.h}) * rot_cos;
            r_hs <= $signed({1'b0, geo_d.h}) * rot_sin;
            r_pcx <= geo_d.cx;
            r_pcy <= geo_d.cy;
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= cxs + POS_W'(xo[k]);
                r_py[k] <= cys + POS_W'(yo[k]);
            end
        end
    end

    // Vectoring CORDICs, one per corner
    logic [15:0] ang [4];
    for (genvar c = 0; c < 4; c++) begin : g_corner
        rrai_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec (
            .i_clk(i_clk), .i_adv(adv), .i_x(r_px[c]), .i_y(r_py[c]),
            .o_angle(ang[c])
        );
    end

    logic [VEC_LAT-1:0] r_vv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv <= '0;
        end else if (adv) begin
            r_vv <= {r_vv[VEC_LAT-2:0], r_sv};
        end
    end

    // Reduction: pairwise min/max, then final
    logic [15:0] r_lo0, r_lo1, r_hi0, r_hi1;
    logic        r_mv;
    logic [15:0] lo, hi, span;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lo0 <= (ang[0] < ang[1]) ? ang[0] : ang[1];
            r_hi0 <= (ang[0] > ang[1]) ? ang[0] : ang[1];
            r_lo1 <= (ang[2] < ang[3]) ? ang[2] : ang[3];
            r_hi1 <= (ang[2] > ang[3]) ? ang[2] : ang[3];
        end
    end
    always_comb begin
        lo = (r_lo0 < r_lo1) ? r_lo0 : r_lo1;
        hi = (r_hi0 > r_hi1) ? r_hi0 : r_hi1;
        span = hi - lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_mv <= r_vv[VEC_LAT-1];
            o_out_valid <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (span > ANG_HALF) begin
                o_start_angle <= 17'd0;
                o_end_angle <= 17'd65536;
                o_full_circle <= 1'b1;
            end else begin
                o_start_angle <= {1'b0, lo};
                o_end_angle <= {1'b0, hi};
                o_full_circle <= 1'b0;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_start_angle))
        else $error("output not held under stall");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_circle |-> o_start_angle == 17'd0
        && o_end_angle == 17'd65536)
        else $error("full circle fields wrong");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_start_angle <= o_end_angle)
        else $error("start after end");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while output empty");

endmodule

/* verif/rrai_checker.sv */
// Checker for the rotated rectangle angular interval block: predicts each
// result from the accepted rectangles and compares. Uses rrai_pkg.
module rrai_checker import rrai_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [19:0] i_center_x,
    input  logic signed [19:0] i_center_y,
    input  logic [15:0]        i_rect_width,
    input  logic [15:0]        i_rect_height,
    input  logic [15:0]        i_rotation_turns,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [16:0]        i_start_angle,
    input  logic [16:0]        i_end_angle,
    input  logic               i_full_circle,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [16:0] start_angle;
        logic [16:0] end_angle;
        logic        full_circle;
    } t_interval;

    t_interval interval_q[$];

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    // Own copy of the arctangent table, 2^32 per turn
    function automatic longint atan_lut(int i);
        longint lut[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325,
            162, 81};
        return lut[i];
    endfunction

    function automatic void rotate_sin_cos(logic [15:0] turns, output longint cs,
                                           output longint sn);
        longint theta, t, qraw, z, x, y, dx, dy;
        int q;
        theta = longint'(turns) << 16;
        t = theta + 64'sd536870912;
        qraw = t >> 30;
        q = int'(qraw & 3);
        z = theta - (qraw << 30);
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_lut(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_lut(i));
            end
        end
        case (q)
            0: begin cs = x; sn = y; end
            1: begin cs = -y; sn = x; end
            2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic logic [31:0] corner_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        if (y == 0) return (x < 0) ? 32'd32768 : 32'd0;
        if (x == 0) return (y > 0) ? 32'd16384 : 32'd49152;
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd2147483648;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_lut(i);
            end else begin
                x -= dx; y += dy; z -= atan_lut(i);
            end
        end
        return {16'd0, z[31:16]};
    endfunction

    function automatic t_interval predict_interval(logic signed [19:0] cx_in,
            logic signed [19:0] cy_in, logic [15:0] w, logic [15:0] h,
            logic [15:0] rot);
        longint cx, cy, cs, sn, px, py, xr, yr;
        logic [31:0] lo, hi, a;
        t_interval r;
        int sgx[4] = '{-1, 1, 1, -1};
        int sgy[4] = '{-1, -1, 1, 1};
        cx = longint'(cx_in) * 1048576;
        cy = longint'(cy_in) * 1048576;
        lo = 32'hFFFF_FFFF;
        hi = 0;
        rotate_sin_cos(rot, cs, sn);
        for (int k = 0; k < 4; k++) begin
            px = sgx[k] * longint'(w);
            py = sgy[k] * longint'(h);
            xr = fshr(px * cs - py * sn, 11);
            yr = fshr(px * sn + py * cs, 11);
            a = corner_angle(cx + xr, cy + yr);
            if (a < lo) lo = a;
            if (a > hi) hi = a;
        end
        if (hi - lo > 32'd32768) begin
            r.start_angle = 0; r.end_angle = 17'd65536; r.full_circle = 1'b1;
        end else begin
            r.start_angle = lo[16:0]; r.end_angle = hi[16:0]; r.full_circle = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_interval exp_r;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (interval_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result transaction");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = interval_q.pop_front();
                    if (exp_r.start_angle !== i_start_angle ||
                        exp_r.end_angle !== i_end_angle ||
                        exp_r.full_circle !== i_full_circle) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                exp_r.start_angle, exp_r.end_angle, exp_r.full_circle,
                                i_start_angle, i_end_angle, i_full_circle);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                interval_q = {interval_q, predict_interval(i_center_x, i_center_y,
                    i_rect_width, i_rect_height, i_rotation_turns)};
        end
        o_pending <= interval_q.size();
    end

endmodule

/* verif/rotated_rect_angular_interval_tb.sv */
// Testbench top: drives rectangles with random idling and stalls, gives the
// verdict. Uses rotated_rect_angular_interval and rrai_checker.
module rotated_rect_angular_interval_tb;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [19:0] center_x = '0;
    logic signed [19:0] center_y = '0;
    logic [15:0]        rect_width = '0;
    logic [15:0]        rect_height = '0;
    logic [15:0]        rotation_turns = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [16:0]        start_angle;
    logic [16:0]        end_angle;
    logic               full_circle;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rotated_rect_angular_interval dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_center_x(center_x), .i_center_y(center_y), .i_rect_width(rect_width),
        .i_rect_height(rect_height), .i_rotation_turns(rotation_turns),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_start_angle(start_angle), .o_end_angle(end_angle),
        .o_full_circle(full_circle)
    );

    rrai_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_center_x(center_x), .i_center_y(center_y), .i_rect_width(rect_width),
        .i_rect_height(rect_height), .i_rotation_turns(rotation_turns),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_start_angle(start_angle), .i_end_angle(end_angle),
        .i_full_circle(full_circle), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (cycle_count > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one rectangle and hold it until accepted
    task automatic send_rect(logic signed [19:0] cx, logic signed [19:0] cy,
                             logic [15:0] w, logic [15:0] h, logic [15:0] rot);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        center_x <= cx;
        center_y <= cy;
        rect_width <= w;
        rect_height <= h;
        rotation_turns <= rot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random;
        logic signed [19:0] cx, cy;
        logic [15:0] w, h;
        cx = 20'($urandom);
        cy = 20'($urandom);
        w = 16'($urandom);
        h = 16'($urandom);
        case ($urandom_range(3))
            0: begin cx = $signed(20'($urandom_range(255))) - 20'sd128; end
            1: begin w = 16'($urandom_range(3)); h = 16'($urandom_range(3)); end
            2: begin cy = '0; end
            default: ;
        endcase
        send_rect(cx, cy, w, h, 16'($urandom));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // extremes, origin corners, axis corners, wide spans
        send_rect(0, 0, 0, 0, 0);
        send_rect(20'sh7FFFF, 20'sh7FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_rect(-20'sd524288, -20'sd524288, 0, 0, 0);
        send_rect(20'sh7FFFF, 0, 0, 0, 0);
        send_rect(-20'sd524288, 0, 0, 0, 0);
        send_rect(0, 20'sh7FFFF, 0, 0, 0);
        send_rect(0, -20'sd524288, 0, 0, 0);
        send_rect(0, 0, 16'hFFFF, 16'hFFFF, 0);
        send_rect(0, 0, 256, 0, 0);
        send_rect(1000, 0, 512, 512, 16384);
        send_rect(1000, 0, 512, 512, 32768);
        send_rect(1000, 0, 512, 512, 49152);
        send_rect(1000, 1000, 16'hFFFF, 16'hFFFF, 8192);
        send_rect(-1000, 0, 100, 100, 0);
        send_rect(0, -1, 2, 2, 0);
        send_rect(20'sh55555, 20'shAAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_rect(20'shAAAAA, 20'sh55555, 16'hAAAA, 16'h5555, 16'hAAAA);
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 82 : 33) : 0;
            stall_pct = (phase == 2) ? 82 : ((phase == 3) ? 33 : 0);
            for (int n = 0; n < 375; n++) send_random();
            drain();
        end
        stall_pct = 0;
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
